// ===== rtl/blend_weight_quantizer_defines.svh =====
// Assertion macros for the blend weight quantizer checker.
// Used by bwq_checker; depends on nothing else.
`ifndef BLEND_WEIGHT_QUANTIZER_DEFINES_SVH
`define BLEND_WEIGHT_QUANTIZER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define BWQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bwq: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define BWQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bwq: next-cycle check failed");

// Holds at the edge after every edge seen while reset is asserted; the first
// reset edge may still show the power-up value.
`define BWQ_ASSERT_RST(lbl, clk, rst_n, cons) \
	lbl: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
		else $error("bwq: reset check failed");

`endif

// ===== rtl/bwq_pkg.sv =====
// Shared widths and constants of the blend weight quantizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package bwq_pkg;

	localparam int W_BITS = 24;                 // raw weight, signed Q8.16
	localparam int CW_BITS = 23;                // clamped weight, never negative
	localparam int Q_BITS = 8;                  // share width, one quotient bit per stage
	localparam int NUM_SCALE = 510;             // 2 * full scale
	localparam int NUM_EXTRA_W = 9;             // bits of NUM_SCALE
	localparam logic [Q_BITS-1:0] FULL_SCALE = 8'd255;

	localparam int FRONT_STAGES = 4;            // clamp, pair sums, total, numerators
	localparam int DIV_STAGES = Q_BITS;         // restoring divider
	localparam int MERGE_STAGES = 2;            // share pair sums, correction

endpackage

`default_nettype wire

// ===== rtl/blend_weight_quantizer.sv =====
// Blend weight quantizer, top level.
// Pipeline: 4 front stages, 8 divider stages and 2 merge stages between an
//   input transfer and its result. Throughput: one item per cycle unless
//   the output stalls; set by the per-lane pipelined divider.
// Reset: arst_n clears only the stage valid bits; data registers are not reset.
`default_nettype none

// Structure:
//   bwq_front  clamp negatives, pairwise sum/max, total and first largest lane,
//              dividend 510*w + sum and divisor 2*sum
//   bwq_lane   one per lane, restoring divider producing one quotient bit per
//              stage, i.e. floor((510*w + sum) / (2*sum)) = round(255*w/sum)
//   bwq_merge  adds the shares and adds 255 minus that total to the first
//              largest lane's share; if all clamp to zero, lane 0 gets 255
//
// Flow control: every stage has its own valid bit and loads whenever it is
// empty or the stage after it moves, so bubbles collapse and input is taken
// while a finished result still waits at the output register, given a bubble.

module blend_weight_quantizer
	import bwq_pkg::*;
#(
	parameter int LANES = 4
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// input item
	input  wire logic                    s_axis_tvalid,
	output logic                         s_axis_tready,
	// weight_0 .. weight_{LANES-1}, 24 bits each, lane 0 in the lowest bits
	input  wire logic [LANES*W_BITS-1:0] s_axis_tdata,
	// result item
	output logic                         m_axis_tvalid,
	input  wire logic                    m_axis_tready,
	// share_0 .. share_{LANES-1}, 8 bits each, lane 0 in the lowest bits
	output logic      [LANES*Q_BITS-1:0] m_axis_tdata
);

	localparam int IDX_W = $clog2(LANES);
	// clamped weights are below 2^23, so LANES of them fit in SUM_W bits
	localparam int SUM_W = CW_BITS + $clog2(LANES);
	localparam int NW = SUM_W + NUM_EXTRA_W;
	localparam int NUM_STG = FRONT_STAGES + DIV_STAGES + MERGE_STAGES;
	localparam int DIV_LO = FRONT_STAGES;
	localparam int MRG_LO = FRONT_STAGES + DIV_STAGES;

	logic [NUM_STG-1:0] vld_q;
	logic [NUM_STG-1:0] stage_en;

	logic [NW-1:0]      num [LANES];
	logic [SUM_W:0]     den;
	logic [IDX_W-1:0]   best_f;
	logic               zero_f;
	logic [Q_BITS-1:0]  share [LANES];

	// side band beside the divider: which lane absorbs the rounding error,
	// and whether the clamped sum was zero
	logic [IDX_W-1:0]   best_sd [DIV_STAGES];
	logic               zero_sd [DIV_STAGES];

	// a stage may load when it is empty or its contents move on
	always_comb begin
		stage_en[NUM_STG-1] = !vld_q[NUM_STG-1] || m_axis_tready;
		for (int k = NUM_STG - 2; k >= 0; k--) begin
			stage_en[k] = !vld_q[k] || stage_en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (stage_en[0]) begin
				vld_q[0] <= s_axis_tvalid;
			end
			for (int k = 1; k < NUM_STG; k++) begin
				if (stage_en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_axis_tready = stage_en[0];
	assign m_axis_tvalid = vld_q[NUM_STG-1];

	bwq_front #(
		.LANES (LANES),
		.SUM_W (SUM_W),
		.IDX_W (IDX_W)
	) u_front (
		.clk     (clk),
		.en      (stage_en[FRONT_STAGES-1:0]),
		.weights (s_axis_tdata),
		.num     (num),
		.den     (den),
		.best    (best_f),
		.zero    (zero_f)
	);

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		bwq_lane #(
			.SUM_W (SUM_W)
		) u_lane (
			.clk   (clk),
			.en    (stage_en[DIV_LO +: DIV_STAGES]),
			.num   (num[i]),
			.den   (den),
			.share (share[i])
		);
	end

	always_ff @(posedge clk) begin
		if (stage_en[DIV_LO]) begin
			best_sd[0] <= best_f;
			zero_sd[0] <= zero_f;
		end
		for (int k = 1; k < DIV_STAGES; k++) begin
			if (stage_en[DIV_LO + k]) begin
				best_sd[k] <= best_sd[k-1];
				zero_sd[k] <= zero_sd[k-1];
			end
		end
	end

	bwq_merge #(
		.LANES (LANES),
		.IDX_W (IDX_W)
	) u_merge (
		.clk      (clk),
		.en       (stage_en[MRG_LO +: MERGE_STAGES]),
		.share_in (share),
		.best     (best_sd[DIV_STAGES-1]),
		.zero     (zero_sd[DIV_STAGES-1]),
		.shares   (m_axis_tdata)
	);

endmodule

`default_nettype wire

// ===== rtl/bwq_front.sv =====
// Front end: clamps weights, sums them, finds the first largest lane and forms
// each lane's dividend and the shared divisor. Depends on bwq_pkg.
`default_nettype none

module bwq_front
	import bwq_pkg::*;
#(
	parameter int LANES = 4,
	parameter int SUM_W = 25,
	parameter int IDX_W = 2
) (
	input  wire logic                            clk,
	input  wire logic [FRONT_STAGES-1:0]         en,
	input  wire logic [LANES*W_BITS-1:0]         weights,
	output logic      [SUM_W+NUM_EXTRA_W-1:0]    num [LANES],
	output logic      [SUM_W:0]                  den,
	output logic      [IDX_W-1:0]                best,
	output logic                                 zero
);

	localparam int NP = (LANES + 1) / 2;
	localparam int NW = SUM_W + NUM_EXTRA_W;
	localparam int PSW = CW_BITS + 1;

	logic [CW_BITS-1:0] w_s1 [LANES];
	logic [CW_BITS-1:0] w_s2 [LANES];
	logic [CW_BITS-1:0] w_s3 [LANES];
	logic [PSW-1:0]     psum_s2 [NP];
	logic [CW_BITS-1:0] pmax_s2 [NP];
	logic [IDX_W-1:0]   pidx_s2 [NP];
	logic [SUM_W-1:0]   sum_s3;
	logic [IDX_W-1:0]   best_s3;
	logic [NW-1:0]      num_s4 [LANES];
	logic [SUM_W:0]     den_s4;
	logic [IDX_W-1:0]   best_s4;
	logic               zero_s4;

	logic [PSW-1:0]     psum_c [NP];
	logic [CW_BITS-1:0] pmax_c [NP];
	logic [IDX_W-1:0]   pidx_c [NP];
	logic [SUM_W-1:0]   sum_c;
	logic [IDX_W-1:0]   best_c;

	// stage 1: clamp negatives to zero
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < LANES; i++) begin
				w_s1[i] <= weights[i*W_BITS + W_BITS - 1] ? '0
					: weights[i*W_BITS +: CW_BITS];
			end
		end
	end

	// stage 2: pairwise sum and pairwise max (even lane wins a tie)
	always_comb begin
		logic [CW_BITS-1:0] a, b;
		for (int j = 0; j < NP; j++) begin
			a = w_s1[2*j];
			b = (2*j + 1 < LANES) ? w_s1[(2*j + 1) % LANES] : '0;
			psum_c[j] = {1'b0, a} + {1'b0, b};
			if (b > a) begin
				pmax_c[j] = b;
				pidx_c[j] = IDX_W'(2*j + 1);
			end else begin
				pmax_c[j] = a;
				pidx_c[j] = IDX_W'(2*j);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			w_s2 <= w_s1;
			psum_s2 <= psum_c;
			pmax_s2 <= pmax_c;
			pidx_s2 <= pidx_c;
		end
	end

	// stage 3: total and first largest over the pairs
	always_comb begin
		logic [CW_BITS-1:0] bv;
		sum_c = '0;
		bv = pmax_s2[0];
		best_c = pidx_s2[0];
		for (int j = 0; j < NP; j++) begin
			sum_c = sum_c + SUM_W'(psum_s2[j]);
			if (pmax_s2[j] > bv) begin
				bv = pmax_s2[j];
				best_c = pidx_s2[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			w_s3 <= w_s2;
			sum_s3 <= sum_c;
			best_s3 <= best_c;
		end
	end

	// stage 4: dividend 510*w + sum, divisor 2*sum
	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < LANES; i++) begin
				num_s4[i] <= NW'(w_s3[i]) * NW'(NUM_SCALE) + NW'(sum_s3);
			end
			den_s4 <= {sum_s3, 1'b0};
			best_s4 <= best_s3;
			zero_s4 <= (sum_s3 == '0);
		end
	end

	assign num = num_s4;
	assign den = den_s4;
	assign best = best_s4;
	assign zero = zero_s4;

endmodule

`default_nettype wire

// ===== rtl/bwq_lane.sv =====
// One lane's pipelined restoring divider, one quotient bit per stage.
// Depends on bwq_pkg.
`default_nettype none

module bwq_lane
	import bwq_pkg::*;
#(
	parameter int SUM_W = 25
) (
	input  wire logic                         clk,
	input  wire logic [DIV_STAGES-1:0]        en,
	input  wire logic [SUM_W+NUM_EXTRA_W-1:0] num,
	input  wire logic [SUM_W:0]               den,
	output logic      [Q_BITS-1:0]            share
);

	localparam int NW = SUM_W + NUM_EXTRA_W;

	// remainder and divisor are not needed after the last stage
	logic [NW-1:0]     rem_s [DIV_STAGES-1];
	logic [SUM_W:0]    den_s [DIV_STAGES-1];
	logic [Q_BITS-1:0] quo_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		localparam int SH = DIV_STAGES - 1 - k;

		logic [NW-1:0]     rem_in;
		logic [SUM_W:0]    den_in;
		logic [Q_BITS-1:0] quo_in;
		logic [NW:0]       diff;
		logic              fits;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign diff = {1'b0, rem_in} - {1'b0, NW'(den_in) << SH};
		assign fits = !diff[NW];

		always_ff @(posedge clk) begin
			if (en[k]) begin
				quo_s[k] <= {quo_in[Q_BITS-2:0], fits};
			end
		end

		if (k < DIV_STAGES - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en[k]) begin
					rem_s[k] <= fits ? diff[NW-1:0] : rem_in;
					den_s[k] <= den_in;
				end
			end
		end
	end

	assign share = quo_s[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/bwq_merge.sv =====
// Merge stage: sums the lane shares, hands the difference to 255 to the first
// largest lane, handles the all-zero case. Output register of the block.
// Depends on bwq_pkg.
`default_nettype none

module bwq_merge
	import bwq_pkg::*;
#(
	parameter int LANES = 4,
	parameter int IDX_W = 2
) (
	input  wire logic                      clk,
	input  wire logic [MERGE_STAGES-1:0]   en,
	input  wire logic [Q_BITS-1:0]         share_in [LANES],
	input  wire logic [IDX_W-1:0]          best,
	input  wire logic                      zero,
	output logic      [LANES*Q_BITS-1:0]   shares
);

	localparam int NP = (LANES + 1) / 2;

	logic [Q_BITS-1:0]     share_s1 [LANES];
	logic [Q_BITS:0]       psum_s1 [NP];
	logic [IDX_W-1:0]      best_s1;
	logic                  zero_s1;
	logic [LANES*Q_BITS-1:0] out_s2;

	logic [Q_BITS:0]       psum_c [NP];
	logic [Q_BITS-1:0]     total_c;
	logic [LANES*Q_BITS-1:0] out_c;

	always_comb begin
		logic [Q_BITS-1:0] b;
		for (int j = 0; j < NP; j++) begin
			b = (2*j + 1 < LANES) ? share_in[(2*j + 1) % LANES] : '0;
			psum_c[j] = {1'b0, share_in[2*j]} + {1'b0, b};
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			share_s1 <= share_in;
			psum_s1 <= psum_c;
			best_s1 <= best;
			zero_s1 <= zero;
		end
	end

	// only the low byte of the share total matters: the result is taken mod 256
	always_comb begin
		total_c = '0;
		for (int j = 0; j < NP; j++) begin
			total_c = total_c + psum_s1[j][Q_BITS-1:0];
		end
		for (int i = 0; i < LANES; i++) begin
			if (zero_s1) begin
				out_c[i*Q_BITS +: Q_BITS] = (i == 0) ? FULL_SCALE : '0;
			end else if (IDX_W'(i) == best_s1) begin
				out_c[i*Q_BITS +: Q_BITS] = share_s1[i] + FULL_SCALE - total_c;
			end else begin
				out_c[i*Q_BITS +: Q_BITS] = share_s1[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			out_s2 <= out_c;
		end
	end

	assign shares = out_s2;

endmodule

`default_nettype wire

// ===== rtl/bwq_checker.sv =====
// Port-level checks for blend_weight_quantizer, attached by bind below.
// Depends on bwq_pkg and blend_weight_quantizer_defines.svh.
`default_nettype none

`include "blend_weight_quantizer_defines.svh"

module bwq_checker
	import bwq_pkg::*;
#(
	parameter int LANES = 4
) (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    s_axis_tvalid,
	input wire logic                    s_axis_tready,
	input wire logic [LANES*W_BITS-1:0] s_axis_tdata,
	input wire logic                    m_axis_tvalid,
	input wire logic                    m_axis_tready,
	input wire logic [LANES*Q_BITS-1:0] m_axis_tdata
);

	logic [Q_BITS-1:0] share_total;
	logic              in_xfer;

	always_comb begin
		share_total = '0;
		for (int i = 0; i < LANES; i++) begin
			share_total = share_total + m_axis_tdata[i*Q_BITS +: Q_BITS];
		end
	end

	// input data is only of interest when a transfer happens
	assign in_xfer = s_axis_tvalid && s_axis_tready && (^s_axis_tdata || 1'b1);

	// no result may be offered while reset holds the pipeline empty
	`BWQ_ASSERT_RST(a_rst_empty, clk, arst_n, !m_axis_tvalid)

	// every result's shares add up to full scale
	`BWQ_ASSERT_IMP(a_full_scale, clk, arst_n, m_axis_tvalid, share_total == FULL_SCALE)

	// the input is refused only when the pipeline is backed up from the output
	`BWQ_ASSERT_IMP(a_stall_cause, clk, arst_n, !s_axis_tready,
		m_axis_tvalid && !m_axis_tready && !in_xfer)

	// a result stalled at the output stays put
	`BWQ_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind blend_weight_quantizer bwq_checker #(
	.LANES (LANES)
) u_bwq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
